@@ rtl/lseg_pkg.sv @@
// ----------------------------------------------------------------------------
// lseg_pkg
// Shared types, codes and color functions of the LED strip effect generator.
// ----------------------------------------------------------------------------
package lseg_pkg;

    localparam int PIX_IDX_W = 6;
    localparam int COLOR_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 2'd2;

    // effect modes
    localparam logic [3:0] MODE_OFF         = 4'd0;
    localparam logic [3:0] MODE_SPREAD      = 4'd1;
    localparam logic [3:0] MODE_UNIFORM     = 4'd2;
    localparam logic [3:0] MODE_STATIC_LAST = 4'd14;

    localparam logic [10:0] SPREAD_PHASE_MAX = 11'd1279;   // wraps at 256*5
    localparam logic [7:0]  LEVEL_MAX        = 8'd255;
    localparam logic [12:0] PCT_RECIP        = 13'd5243;   // 2^19 / 100, rounded up
    localparam int          PCT_SHIFT        = 19;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        FILL_KEEP,
        FILL_CONST,
        FILL_WHEEL
    } fill_kind_t;

    // color wheel, returns {red, green, blue}
    function automatic logic [COLOR_W-1:0] wheel_color(input logic [7:0] pos);
        logic [7:0] q;
        logic [7:0] r;
        logic [9:0] q3;
        begin
            q = ~pos;
            if (q < 8'd85) begin
                q3 = 10'(q) * 10'd3;
                wheel_color = {8'(10'd255 - q3), 8'd0, q3[7:0]};
            end
            else if (q < 8'd170) begin
                r = q - 8'd85;
                q3 = 10'(r) * 10'd3;
                wheel_color = {8'd0, q3[7:0], 8'(10'd255 - q3)};
            end
            else begin
                r = q - 8'd170;
                q3 = 10'(r) * 10'd3;
                wheel_color = {q3[7:0], 8'(10'd255 - q3), 8'd0};
            end
        end
    endfunction

    // fixed palette of the static color modes
    function automatic logic [COLOR_W-1:0] fixed_color(input logic [3:0] mode);
        begin
            unique case (mode)
                4'd3:    fixed_color = {8'd255, 8'd0,   8'd0};
                4'd4:    fixed_color = {8'd250, 8'd25,  8'd0};
                4'd5:    fixed_color = {8'd240, 8'd50,  8'd0};
                4'd6:    fixed_color = {8'd210, 8'd75,  8'd0};
                4'd7:    fixed_color = {8'd180, 8'd140, 8'd0};
                4'd8:    fixed_color = {8'd110, 8'd200, 8'd0};
                4'd9:    fixed_color = {8'd0,   8'd255, 8'd0};
                4'd10:   fixed_color = {8'd0,   8'd150, 8'd200};
                4'd11:   fixed_color = {8'd0,   8'd0,   8'd255};
                4'd12:   fixed_color = {8'd60,  8'd0,   8'd170};
                4'd13:   fixed_color = {8'd130, 8'd0,   8'd180};
                4'd14:   fixed_color = {8'd180, 8'd0,   8'd70};
                default: fixed_color = '0;
            endcase
        end
    endfunction

endpackage

@@ rtl/led_strip_effect_generator_top.sv @@
// ----------------------------------------------------------------------------
// led_strip_effect_generator_top
// Paints a stored pixel buffer by effect mode and streams the frame out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, now_ms): one update request per frame.
//   Output channel (out_valid/out_stall): PIXEL_COUNT results per request, in
//   pixel order, last_pixel set on the final one.
//   Config port (cfg_we/cfg_index/cfg_data): write only while idle.
//   A taken request starts the sequencer; pixel 0 passes the memory read
//   stage and then the output register. The sequencer walks the pixel memory
//   one entry per cycle unless stalled, and in_stall stays high while it runs.
//   A stalled output holds its pixel; the sequencer halts behind it and the
//   memory read stage holds its data.
//   Reset: buffer reads as black (per-entry valid bits clear), phases and
//   timestamps clear, effect_mode 0, brightness 0, interval 50 ms.
// ----------------------------------------------------------------------------
module led_strip_effect_generator_top #(
    parameter int PIXEL_COUNT = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [31:0]                           now_ms,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [lseg_pkg::PIX_IDX_W-1:0]        pixel_index,
    output logic [7:0]                            red,
    output logic [7:0]                            green,
    output logic [7:0]                            blue,
    output logic [7:0]                            brightness_level,
    output logic                                  last_pixel,
    input  logic                                  cfg_we,
    input  logic [lseg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lseg_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int IDX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int SPREAD_STEP = 256 / PIXEL_COUNT;
    localparam int SPREAD_REM  = 256 % PIXEL_COUNT;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

    // configuration registers
    logic [3:0]  effect_mode_reg;
    logic [6:0]  brightness_pct_reg;
    logic [15:0] interval_ms_reg;
    logic [7:0]  level_reg;

    // effect state
    logic [10:0] spread_phase_reg,  spread_phase_next;
    logic [7:0]  uniform_phase_reg, uniform_phase_next;
    logic [31:0] spread_last_reg,   spread_last_next;
    logic [31:0] uniform_last_reg,  uniform_last_next;

    // sequencer
    lseg_pkg::state_t     state_reg, state_next;
    lseg_pkg::fill_kind_t fill_reg,  fill_next;
    logic [lseg_pkg::COLOR_W-1:0] const_color_reg, const_color_next;
    logic                 spread_reg, spread_next;
    logic [IDX_W-1:0]     idx_reg,    idx_next;
    logic [7:0]           pos_reg,    pos_next;
    logic [6:0]           rem_reg,    rem_next;

    // read stage
    logic                 s2_valid_reg, s2_valid_next;
    logic [IDX_W-1:0]     s2_idx_reg;
    logic                 s2_last_reg;
    logic                 s2_new_reg;
    logic                 s2_written_reg;
    logic [lseg_pkg::COLOR_W-1:0] s2_color_reg;

    // output register
    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic [lseg_pkg::COLOR_W-1:0] out_color_reg;
    logic [7:0]           out_level_reg;
    logic                 out_last_reg;

    // pixel memory
    logic [lseg_pkg::COLOR_W-1:0] pix_mem [PIXEL_COUNT];
    logic [lseg_pkg::COLOR_W-1:0] mem_rdata_reg;
    logic [PIXEL_COUNT-1:0]       written_reg;
    logic                         mem_we;
    logic                         mem_re;
    logic [lseg_pkg::COLOR_W-1:0] new_color;

    logic        in_accept;
    logic        s2_adv;
    logic        issue;
    logic        spread_due;
    logic        uniform_due;
    logic [6:0]  rem_sum;
    logic        rem_carry;
    logic [14:0] pct_x255;
    logic [27:0] level_prod;
    logic [8:0]  level_raw;
    logic [lseg_pkg::COLOR_W-1:0] s2_out_color;

    assign in_stall  = (state_reg != lseg_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign s2_adv = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign issue  = (state_reg == lseg_pkg::ST_RUN) && (!s2_valid_reg || s2_adv);

    assign spread_due  = ((now_ms - spread_last_reg)  >= 32'(interval_ms_reg));
    assign uniform_due = ((now_ms - uniform_last_reg) >= 32'(interval_ms_reg));

    assign new_color = (fill_reg == lseg_pkg::FILL_CONST) ? const_color_reg
                                                          : lseg_pkg::wheel_color(pos_reg);
    assign mem_we = issue && (fill_reg != lseg_pkg::FILL_KEEP);
    assign mem_re = issue && (fill_reg == lseg_pkg::FILL_KEEP);

    // spread offset i*256/N built up one pixel at a time
    assign rem_sum   = rem_reg + 7'(SPREAD_REM);
    assign rem_carry = spread_reg && (rem_sum >= 7'(PIXEL_COUNT));

    // level = pct*255/100, by reciprocal multiply
    assign pct_x255   = {brightness_pct_reg, 8'd0} - 15'(brightness_pct_reg);
    assign level_prod = 28'(pct_x255) * 28'(lseg_pkg::PCT_RECIP);
    assign level_raw  = level_prod[lseg_pkg::PCT_SHIFT +: 9];

    assign s2_out_color = s2_new_reg     ? s2_color_reg  :
                          s2_written_reg ? mem_rdata_reg : '0;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_mode_reg    <= lseg_pkg::MODE_OFF;
            brightness_pct_reg <= '0;
            interval_ms_reg    <= 16'd50;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lseg_pkg::REG_EFFECT_MODE: effect_mode_reg    <= cfg_data[3:0];
                lseg_pkg::REG_BRIGHTNESS:  brightness_pct_reg <= cfg_data[6:0];
                lseg_pkg::REG_INTERVAL:    interval_ms_reg    <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= (level_raw > 9'(lseg_pkg::LEVEL_MAX)) ? lseg_pkg::LEVEL_MAX
                                                           : level_raw[7:0];
    end

    // next state: request decode and pixel walk
    always_comb
    begin
        state_next         = state_reg;
        fill_next          = fill_reg;
        const_color_next   = const_color_reg;
        spread_next        = spread_reg;
        idx_next           = idx_reg;
        pos_next           = pos_reg;
        rem_next           = rem_reg;
        spread_phase_next  = spread_phase_reg;
        uniform_phase_next = uniform_phase_reg;
        spread_last_next   = spread_last_reg;
        uniform_last_next  = uniform_last_reg;

        unique case (state_reg)
            lseg_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next       = lseg_pkg::ST_RUN;
                    idx_next         = '0;
                    rem_next         = '0;
                    fill_next        = lseg_pkg::FILL_KEEP;
                    const_color_next = '0;
                    spread_next      = 1'b0;
                    pos_next         = '0;
                    priority if (effect_mode_reg == lseg_pkg::MODE_OFF)
                    begin
                        fill_next = lseg_pkg::FILL_CONST;
                    end
                    else if (effect_mode_reg == lseg_pkg::MODE_SPREAD)
                    begin
                        if (spread_due)
                        begin
                            fill_next         = lseg_pkg::FILL_WHEEL;
                            spread_next       = 1'b1;
                            pos_next          = spread_phase_reg[7:0];
                            spread_last_next  = now_ms;
                            spread_phase_next = (spread_phase_reg == lseg_pkg::SPREAD_PHASE_MAX)
                                                ? 11'd0 : spread_phase_reg + 11'd1;
                        end
                    end
                    else if (effect_mode_reg == lseg_pkg::MODE_UNIFORM)
                    begin
                        if (uniform_due)
                        begin
                            fill_next          = lseg_pkg::FILL_WHEEL;
                            pos_next           = uniform_phase_reg;
                            uniform_last_next  = now_ms;
                            uniform_phase_next = uniform_phase_reg + 8'd1;
                        end
                    end
                    else if (effect_mode_reg <= lseg_pkg::MODE_STATIC_LAST)
                    begin
                        fill_next        = lseg_pkg::FILL_CONST;
                        const_color_next = lseg_pkg::fixed_color(effect_mode_reg);
                    end
                    else
                    begin
                        fill_next = lseg_pkg::FILL_KEEP;
                    end
                end
            end
            lseg_pkg::ST_RUN:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (spread_reg)
                    begin
                        pos_next = pos_reg + 8'(SPREAD_STEP) + 8'(rem_carry);
                        rem_next = rem_carry ? rem_sum - 7'(PIXEL_COUNT) : rem_sum;
                    end
                    else
                    begin
                        pos_next = pos_reg + 8'd1;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = lseg_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lseg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= lseg_pkg::ST_IDLE;
            fill_reg          <= lseg_pkg::FILL_KEEP;
            spread_reg        <= 1'b0;
            idx_reg           <= '0;
            spread_phase_reg  <= '0;
            uniform_phase_reg <= '0;
            spread_last_reg   <= '0;
            uniform_last_reg  <= '0;
            written_reg       <= '0;
            s2_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            fill_reg          <= fill_next;
            spread_reg        <= spread_next;
            idx_reg           <= idx_next;
            spread_phase_reg  <= spread_phase_next;
            uniform_phase_reg <= uniform_phase_next;
            spread_last_reg   <= spread_last_next;
            uniform_last_reg  <= uniform_last_next;
            s2_valid_reg      <= s2_valid_next;
            if (mem_we)
            begin
                written_reg[idx_reg] <= 1'b1;
            end
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign s2_valid_next = issue ? 1'b1 : (s2_valid_reg && !s2_adv);

    // payload registers
    always_ff @(posedge clk)
    begin
        const_color_reg <= const_color_next;
        pos_reg         <= pos_next;
        rem_reg         <= rem_next;
        if (issue)
        begin
            s2_idx_reg     <= idx_reg;
            s2_last_reg    <= (idx_reg == LAST_IDX);
            s2_new_reg     <= (fill_reg != lseg_pkg::FILL_KEEP);
            s2_written_reg <= written_reg[idx_reg];
            s2_color_reg   <= new_color;
        end
        if (s2_adv)
        begin
            out_idx_reg   <= s2_idx_reg;
            out_color_reg <= s2_out_color;
            out_level_reg <= level_reg;
            out_last_reg  <= s2_last_reg;
        end
    end

    // pixel buffer, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pix_mem[idx_reg] <= new_color;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= pix_mem[idx_reg];
        end
    end

    assign out_valid        = out_valid_reg;
    assign pixel_index      = lseg_pkg::PIX_IDX_W'(out_idx_reg);
    assign red              = out_color_reg[23:16];
    assign green            = out_color_reg[15:8];
    assign blue             = out_color_reg[7:0];
    assign brightness_level = out_level_reg;
    assign last_pixel       = out_last_reg;

`ifndef ASSERT_OFF
    a_mem_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("pixel memory written and read in one cycle");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_adv) |=> (s2_valid_reg && $stable(s2_idx_reg)))
        else $error("read stage lost its pixel under stall");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_idx_reg == LAST_IDX))
        else $error("last pixel mark on wrong index");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        spread_phase_reg <= lseg_pkg::SPREAD_PHASE_MAX)
        else $error("spread phase out of range");

    a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == lseg_pkg::ST_RUN) && (idx_reg == '0))
        else $error("request did not start a frame at pixel zero");
`endif

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED strip effect generator. Drives update
// requests and register writes, predicts every pixel of each frame, and
// checks the pixel stream in order under random idling and back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PIXEL_COUNT  = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;
    localparam int SPREAD_WRAP  = 1280;

    localparam logic [lseg_pkg::CFG_IDX_W-1:0] REG_UNUSED        = 2'd3;
    localparam logic [3:0]                     MODE_STATIC_FIRST = 4'd3;
    localparam logic [3:0]                     MODE_HOLD         = 4'd15;

    typedef struct packed {
        logic [lseg_pkg::PIX_IDX_W-1:0] index;
        logic [7:0]                     red;
        logic [7:0]                     green;
        logic [7:0]                     blue;
        logic [7:0]                     level;
        logic                           last;
    } pixel_t;

    logic                            clk        = 1'b0;
    logic                            rst_n      = 1'b0;
    logic                            in_valid   = 1'b0;
    logic                            in_stall;
    logic [31:0]                     now_ms     = '0;
    logic                            out_valid;
    logic                            out_stall  = 1'b0;
    logic [lseg_pkg::PIX_IDX_W-1:0]  pixel_index;
    logic [7:0]                      red;
    logic [7:0]                      green;
    logic [7:0]                      blue;
    logic [7:0]                      brightness_level;
    logic                            last_pixel;
    logic                            cfg_we     = 1'b0;
    logic [lseg_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [lseg_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

    // predictor state, mirrors the block after reset
    logic [lseg_pkg::COLOR_W-1:0] frame_buf [PIXEL_COUNT];
    int                 spread_phase    = 0;
    int                 uniform_phase   = 0;
    logic [31:0]        spread_last_ms  = '0;
    logic [31:0]        uniform_last_ms = '0;
    logic [3:0]         cur_mode        = lseg_pkg::MODE_OFF;
    logic [6:0]         cur_percent     = '0;
    logic [15:0]        cur_interval    = 16'd50;

    logic [lseg_pkg::COLOR_W-1:0] palette [12] = '{
        {8'd255, 8'd0,   8'd0},   {8'd250, 8'd25,  8'd0},
        {8'd240, 8'd50,  8'd0},   {8'd210, 8'd75,  8'd0},
        {8'd180, 8'd140, 8'd0},   {8'd110, 8'd200, 8'd0},
        {8'd0,   8'd255, 8'd0},   {8'd0,   8'd150, 8'd200},
        {8'd0,   8'd0,   8'd255}, {8'd60,  8'd0,   8'd170},
        {8'd130, 8'd0,   8'd180}, {8'd180, 8'd0,   8'd70}
    };

    pixel_t      pixel_expect_q [$];
    int          fail_count = 0;
    int          stall_hold = 0;
    bit          quiet      = 1'b0;
    logic [31:0] tick_ms    = '0;

    led_strip_effect_generator_top #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .now_ms          (now_ms),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pixel_index     (pixel_index),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .brightness_level(brightness_level),
        .last_pixel      (last_pixel),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < PIXEL_COUNT; i++)
        begin
            frame_buf[i] = '0;
        end
    end

    // color wheel: q = 255 - pos, three ramps of 85 steps
    function automatic logic [lseg_pkg::COLOR_W-1:0] hue_to_rgb(input logic [7:0] pos);
        int q;
        q = 255 - int'(pos);
        if (q < 85)
        begin
            return {8'(255 - 3 * q), 8'd0, 8'(3 * q)};
        end
        else if (q < 170)
        begin
            q = q - 85;
            return {8'd0, 8'(3 * q), 8'(255 - 3 * q)};
        end
        q = q - 170;
        return {8'(3 * q), 8'(255 - 3 * q), 8'd0};
    endfunction

    // repaint the buffer for one request and queue the frame it emits
    function automatic void predict_frame(input logic [31:0] stamp);
        logic [31:0] elapsed;
        int          level;
        pixel_t      px;
        if (cur_mode == lseg_pkg::MODE_OFF)
        begin
            for (int i = 0; i < PIXEL_COUNT; i++)
            begin
                frame_buf[i] = '0;
            end
        end
        else if (cur_mode == lseg_pkg::MODE_SPREAD)
        begin
            elapsed = stamp - spread_last_ms;
            if (elapsed >= {16'd0, cur_interval})
            begin
                spread_last_ms = stamp;
                for (int i = 0; i < PIXEL_COUNT; i++)
                begin
                    frame_buf[i] = hue_to_rgb(8'(i * 256 / PIXEL_COUNT + spread_phase));
                end
                spread_phase++;
                if (spread_phase >= SPREAD_WRAP)
                begin
                    spread_phase = 0;
                end
            end
        end
        else if (cur_mode == lseg_pkg::MODE_UNIFORM)
        begin
            elapsed = stamp - uniform_last_ms;
            if (elapsed >= {16'd0, cur_interval})
            begin
                uniform_last_ms = stamp;
                for (int i = 0; i < PIXEL_COUNT; i++)
                begin
                    frame_buf[i] = hue_to_rgb(8'(i + uniform_phase));
                end
                uniform_phase = (uniform_phase + 1) & 255;
            end
        end
        else if (cur_mode <= lseg_pkg::MODE_STATIC_LAST)
        begin
            for (int i = 0; i < PIXEL_COUNT; i++)
            begin
                frame_buf[i] = palette[cur_mode - MODE_STATIC_FIRST];
            end
        end
        // hold mode: buffer untouched

        level = int'(cur_percent) * 255 / 100;
        if (level > 255)
        begin
            level = 255;
        end
        for (int i = 0; i < PIXEL_COUNT; i++)
        begin
            px.index = lseg_pkg::PIX_IDX_W'(i);
            {px.red, px.green, px.blue} = frame_buf[i];
            px.level = 8'(level);
            px.last  = (i == PIXEL_COUNT - 1);
            pixel_expect_q.push_back(px);
        end
    endfunction

    task automatic log_failure(input string what, input pixel_t want, input pixel_t got);
        if (fail_count < MAX_REPORTS)
        begin
            $display("%s: exp idx=%0d rgb=%0d,%0d,%0d lvl=%0d last=%0b",
                     what, want.index, want.red, want.green, want.blue, want.level,
                     want.last);
            $display("    got idx=%0d rgb=%0d,%0d,%0d lvl=%0d last=%0b",
                     got.index, got.red, got.green, got.blue, got.level, got.last);
        end
        fail_count++;
    endtask

    always @(posedge clk)
    begin : check_pixels
        pixel_t got;
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {pixel_index, red, green, blue, brightness_level, last_pixel};
            if (pixel_expect_q.size() == 0)
            begin
                log_failure("unexpected pixel", '0, got);
            end
            else
            begin
                want = pixel_expect_q.pop_front();
                if (got !== want)
                begin
                    log_failure("pixel mismatch", want, got);
                end
            end
        end
    end

    // receiver: long hold-off when requested, otherwise sparse random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_hold > 0)
        begin
            out_stall <= 1'b1;
            stall_hold = stall_hold - 1;
        end
        else
        begin
            out_stall <= !quiet && ($urandom_range(0, 99) < 7);
        end
    end

    // one update request; returns at the edge it is taken, valid left high
    task automatic offer_update(input logic [31:0] stamp);
        if (!quiet && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        now_ms   <= stamp;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_frame(stamp);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pixel_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lseg_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [lseg_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            lseg_pkg::REG_EFFECT_MODE: cur_mode     = data[3:0];
            lseg_pkg::REG_BRIGHTNESS:  cur_percent  = data[6:0];
            lseg_pkg::REG_INTERVAL:    cur_interval = data;
            default:                   ;
        endcase
    endtask

    task automatic test_reset_frame();
        offer_update(32'hFFFF_FFFF);
        settle();
    endtask

    task automatic test_static_colors();
        write_reg(lseg_pkg::REG_BRIGHTNESS, 16'd100);
        for (int m = MODE_STATIC_FIRST; m <= lseg_pkg::MODE_STATIC_LAST; m++)
        begin
            write_reg(lseg_pkg::REG_EFFECT_MODE, 16'(m));
            offer_update(32'(m));
            settle();
        end
        write_reg(lseg_pkg::REG_EFFECT_MODE, {12'hFFF, lseg_pkg::MODE_OFF});
        offer_update(32'd0);
        settle();
    endtask

    task automatic test_spread_rainbow();
        write_reg(lseg_pkg::REG_EFFECT_MODE, {12'd0, lseg_pkg::MODE_SPREAD});
        // default interval of 50: one short of it, then exactly it
        offer_update(32'd49);
        offer_update(32'd50);
        settle();
        write_reg(lseg_pkg::REG_INTERVAL, 16'd0);
        offer_update(32'd50);
        settle();
    endtask

    task automatic test_uniform_rainbow();
        write_reg(lseg_pkg::REG_INTERVAL, 16'hFFFF);
        write_reg(lseg_pkg::REG_EFFECT_MODE, {12'd0, lseg_pkg::MODE_UNIFORM});
        offer_update(32'hFFFF_FFF0);
        // wraps past zero, elapsed is exactly the interval
        offer_update(32'h0000_FFEF);
        offer_update(32'h0001_0000);
        settle();
    endtask

    task automatic test_hold_brightness();
        logic [lseg_pkg::CFG_DATA_W-1:0] pct [4] = '{16'd99, 16'd100, 16'd101, 16'hFFFF};
        write_reg(lseg_pkg::REG_EFFECT_MODE, {12'd0, MODE_HOLD});
        foreach (pct[k])
        begin
            write_reg(lseg_pkg::REG_BRIGHTNESS, pct[k]);
            offer_update(32'h8000_0000);
            settle();
        end
    endtask

    task automatic test_unused_index();
        write_reg(REG_UNUSED, 16'hFFFF);
        offer_update(32'h1234_5678);
        settle();
    endtask

    // receiver holds off long enough for the block to back up into its input
    task automatic test_backpressure();
        write_reg(lseg_pkg::REG_EFFECT_MODE, {12'd0, lseg_pkg::MODE_UNIFORM});
        write_reg(lseg_pkg::REG_INTERVAL, 16'd0);
        quiet = 1'b1;
        stall_hold = 300;
        for (int k = 0; k < 12; k++)
        begin
            tick_ms = tick_ms + 32'd3;
            offer_update(tick_ms);
        end
        settle();
        quiet = 1'b0;
    endtask

    task automatic test_random_updates(input int phases, input int per_phase);
        int          sel;
        logic [3:0]  mode;
        logic [15:0] pct_data;
        logic [15:0] ival;
        for (int p = 0; p < phases; p++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
            begin
                mode = lseg_pkg::MODE_SPREAD;
            end
            else if (sel < 7)
            begin
                mode = lseg_pkg::MODE_UNIFORM;
            end
            else
            begin
                mode = 4'($urandom_range(0, 15));
            end
            case ($urandom_range(0, 3))
                0:       pct_data = 16'd0;
                1:       pct_data = 16'd100;
                2:       pct_data = 16'($urandom_range(0, 65535));
                default: pct_data = 16'($urandom_range(0, 100));
            endcase
            case ($urandom_range(0, 4))
                0:       ival = 16'd0;
                1:       ival = 16'hFFFF;
                2, 3:    ival = 16'($urandom_range(1, 40));
                default: ival = 16'($urandom_range(0, 65535));
            endcase
            write_reg(lseg_pkg::REG_EFFECT_MODE, {12'($urandom), mode});
            write_reg(lseg_pkg::REG_BRIGHTNESS, pct_data);
            write_reg(lseg_pkg::REG_INTERVAL, ival);
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(REG_UNUSED, 16'($urandom));
            end
            quiet = (p == phases / 2);
            for (int k = 0; k < per_phase; k++)
            begin
                sel = $urandom_range(0, 99);
                // mostly a clock moving on around the interval, some jumps
                if (sel < 80)
                begin
                    tick_ms = tick_ms + 32'($urandom_range(0, 2 * int'(ival) + 2));
                end
                else if (sel < 90)
                begin
                    tick_ms = tick_ms + $urandom;
                end
                else
                begin
                    tick_ms = $urandom;
                end
                offer_update(tick_ms);
            end
            settle();
            quiet = 1'b0;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_frame();
        test_static_colors();
        test_spread_rainbow();
        test_uniform_rainbow();
        test_hold_brightness();
        test_unused_index();
        test_backpressure();
        test_random_updates(10, 43);
        settle();
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/lseg_pkg.sv
rtl/led_strip_effect_generator_top.sv
tb/testbench.sv
